>>> rtl/core/ssc_pkg.sv
package ssc_pkg;

    typedef enum logic [1:0] {
        REQ_UPDATE = 2'd0,
        REQ_LOOKUP = 2'd1,
        REQ_REMOVE = 2'd2
    } req_type_t;

    typedef enum logic [1:0] {
        KIND_STALE = 2'd0,
        KIND_NONE  = 2'd1,
        KIND_DIST  = 2'd2,
        KIND_SEQ   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } stat_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] source;
        logic [31:0] sequence_req;
        logic [15:0] distance;
        logic [31:0] now_ticks;
    } req_t;

    typedef struct packed {
        logic [1:0]  update_kind;
        logic [31:0] entry_time;
        logic        found;
        logic [1:0]  status;
    } rsp_t;

    typedef struct packed {
        logic [31:0] source;
        logic [31:0] seq_num;
        logic [15:0] distance;
        logic [31:0] stamp;
    } entry_t;

endpackage

>>> rtl/core/ssc_mem.sv
module ssc_mem #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
) (
    input  logic                  clk,
    input  logic                  we,
    input  logic [ADDR_W-1:0]     wr_addr,
    input  ssc_pkg::entry_t       wr_data,
    input  logic                  rd_en,
    input  logic [ADDR_W-1:0]     rd_addr,
    output ssc_pkg::entry_t       rd_data
);

    ssc_pkg::entry_t mem [DEPTH];
    ssc_pkg::entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/core/source_sequence_cache.sv
// Source sequence cache. Up to ENTRIES routing sources are kept in insertion
// order in one synchronous memory. An update or lookup request walks the
// stored entries from oldest to newest, one memory read per cycle, and stops
// at the first match; an update then rewrites the matching entry when its
// sequence number is newer or its distance shorter, or on a miss appends a
// new one at the tail unless the table is full. A remove, or any request on an
// empty table, skips the scan. One request is handled at a time; req_ready is
// low while a request is in progress and while its result cannot yet be
// handed to the output register.
module source_sequence_cache #(
    parameter int ENTRIES = 64
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  ssc_pkg::req_t   req,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    output ssc_pkg::rsp_t   rsp
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam logic [IDX_W-1:0] LAST = IDX_W'(ENTRIES - 1);
    localparam logic [CNT_W-1:0] FULL = CNT_W'(ENTRIES);

    function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] p);
        wrap_inc = (p == LAST) ? '0 : IDX_W'(p + 1'b1);
    endfunction

    ssc_pkg::state_t  state_reg, state_next;
    ssc_pkg::req_t    req_reg, req_next;
    ssc_pkg::rsp_t    res_reg, res_next;
    ssc_pkg::rsp_t    rsp_reg, rsp_next;
    logic             rsp_valid_reg, rsp_valid_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] issued_reg, issued_next;
    logic [IDX_W-1:0] oldest_reg, oldest_next;
    logic [IDX_W-1:0] free_reg, free_next;
    logic [IDX_W-1:0] scan_pos_reg, scan_pos_next;
    logic [IDX_W-1:0] data_pos_reg, data_pos_next;
    logic             vld_reg, vld_next;

    logic             mem_we;
    logic [IDX_W-1:0] mem_wr_addr;
    ssc_pkg::entry_t  mem_wr_data;
    logic             mem_rd_en;
    logic [IDX_W-1:0] mem_rd_addr;
    ssc_pkg::entry_t  mem_rd_data;

    logic req_fire;
    logic hit;
    logic miss_end;
    logic rsp_load;

    ssc_mem #(
        .DEPTH  (ENTRIES),
        .ADDR_W (IDX_W)
    ) u_mem (
        .clk     (clk),
        .we      (mem_we),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    assign req_ready = (state_reg == ssc_pkg::ST_IDLE);
    assign req_fire  = req_valid && req_ready;
    assign hit       = vld_reg && (mem_rd_data.source == req_reg.source) &&
                       ((req_reg.req_type != ssc_pkg::REQ_LOOKUP) ||
                        (mem_rd_data.seq_num == req_reg.sequence_req));
    assign miss_end  = !vld_reg && (issued_reg == count_reg);
    assign rsp_load  = (state_reg == ssc_pkg::ST_DONE) && (!rsp_valid_reg || rsp_ready);

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ssc_pkg::ST_IDLE:
            begin
                if (req_fire)
                begin
                    if (((req.req_type == ssc_pkg::REQ_UPDATE) ||
                         (req.req_type == ssc_pkg::REQ_LOOKUP)) && (count_reg != '0))
                    begin
                        state_next = ssc_pkg::ST_SCAN;
                    end
                    else
                    begin
                        state_next = ssc_pkg::ST_DONE;
                    end
                end
            end
            ssc_pkg::ST_SCAN:
            begin
                if (hit || miss_end)
                begin
                    state_next = ssc_pkg::ST_DONE;
                end
            end
            ssc_pkg::ST_DONE:
            begin
                if (rsp_load)
                begin
                    state_next = ssc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ssc_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_next      = req_reg;
        res_next      = res_reg;
        count_next    = count_reg;
        issued_next   = issued_reg;
        oldest_next   = oldest_reg;
        free_next     = free_reg;
        scan_pos_next = scan_pos_reg;
        data_pos_next = data_pos_reg;
        vld_next      = 1'b0;
        mem_we        = 1'b0;
        mem_wr_addr   = free_reg;
        mem_wr_data   = '{source: req_reg.source, seq_num: req_reg.sequence_req,
                          distance: req_reg.distance, stamp: req_reg.now_ticks};
        mem_rd_en     = 1'b0;
        mem_rd_addr   = scan_pos_reg;
        rsp_next      = rsp_reg;

        case (state_reg)
            ssc_pkg::ST_IDLE:
            begin
                if (req_fire)
                begin
                    req_next      = req;
                    res_next      = '0;
                    issued_next   = '0;
                    scan_pos_next = oldest_reg;
                    case (req.req_type)
                        ssc_pkg::REQ_UPDATE:
                        begin
                            if (count_reg == '0)
                            begin
                                mem_we      = 1'b1;
                                mem_wr_data = '{source: req.source, seq_num: req.sequence_req,
                                                distance: req.distance, stamp: req.now_ticks};
                                free_next   = wrap_inc(free_reg);
                                count_next  = CNT_W'(count_reg + 1'b1);
                                res_next.update_kind = ssc_pkg::KIND_SEQ;
                                res_next.entry_time  = req.now_ticks;
                            end
                        end
                        ssc_pkg::REQ_REMOVE:
                        begin
                            if (count_reg == '0)
                            begin
                                res_next.status = ssc_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                oldest_next = wrap_inc(oldest_reg);
                                count_next  = CNT_W'(count_reg - 1'b1);
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ssc_pkg::ST_SCAN:
            begin
                if (!hit && (issued_reg != count_reg))
                begin
                    mem_rd_en     = 1'b1;
                    issued_next   = CNT_W'(issued_reg + 1'b1);
                    scan_pos_next = wrap_inc(scan_pos_reg);
                    vld_next      = 1'b1;
                    data_pos_next = scan_pos_reg;
                end
                if (hit)
                begin
                    if (req_reg.req_type == ssc_pkg::REQ_LOOKUP)
                    begin
                        res_next.found = 1'b1;
                    end
                    else
                    begin
                        mem_wr_addr = data_pos_reg;
                        if (mem_rd_data.seq_num < req_reg.sequence_req)
                        begin
                            mem_we = 1'b1;
                            res_next.update_kind = ssc_pkg::KIND_SEQ;
                            res_next.entry_time  = req_reg.now_ticks;
                        end
                        else if (mem_rd_data.seq_num == req_reg.sequence_req)
                        begin
                            res_next.entry_time = mem_rd_data.stamp;
                            if (mem_rd_data.distance > req_reg.distance)
                            begin
                                mem_we      = 1'b1;
                                mem_wr_data = mem_rd_data;
                                mem_wr_data.distance = req_reg.distance;
                                res_next.update_kind = ssc_pkg::KIND_DIST;
                            end
                            else
                            begin
                                res_next.update_kind = ssc_pkg::KIND_NONE;
                            end
                        end
                    end
                end
                else if (miss_end && (req_reg.req_type == ssc_pkg::REQ_UPDATE))
                begin
                    if (count_reg == FULL)
                    begin
                        res_next.status = ssc_pkg::STAT_FULL;
                    end
                    else
                    begin
                        mem_we     = 1'b1;
                        free_next  = wrap_inc(free_reg);
                        count_next = CNT_W'(count_reg + 1'b1);
                        res_next.update_kind = ssc_pkg::KIND_SEQ;
                        res_next.entry_time  = req_reg.now_ticks;
                    end
                end
            end
            ssc_pkg::ST_DONE:
            begin
                if (rsp_load)
                begin
                    rsp_next = res_reg;
                end
            end
            default:
            begin
            end
        endcase

        rsp_valid_next = rsp_load || (rsp_valid_reg && !rsp_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ssc_pkg::ST_IDLE;
            rsp_valid_reg <= 1'b0;
            count_reg     <= '0;
            oldest_reg    <= '0;
            free_reg      <= '0;
            issued_reg    <= '0;
            vld_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            count_reg     <= count_next;
            oldest_reg    <= oldest_next;
            free_reg      <= free_next;
            issued_reg    <= issued_next;
            vld_reg       <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        res_reg      <= res_next;
        rsp_reg      <= rsp_next;
        scan_pos_reg <= scan_pos_next;
        data_pos_reg <= data_pos_next;
    end

endmodule

>>> test/tb.sv
module tb;

    localparam int TBL_DEPTH = 64;
    localparam int POOL_SIZE = 80;
    localparam int RANDOM_ITEMS = 1700;
    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam logic [1:0] REQ_UNDEF = 2'd3;

    typedef struct {
        ssc_pkg::req_t rq;
        bit            typed;
        ssc_pkg::rsp_t want;
    } dir_row_t;

    logic clk;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    ssc_pkg::req_t req = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    ssc_pkg::rsp_t rsp;

    source_sequence_cache #(.ENTRIES(TBL_DEPTH)) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    // predictor copy of the cache
    logic [31:0] tbl_source [TBL_DEPTH];
    logic [31:0] tbl_seq [TBL_DEPTH];
    logic [15:0] tbl_dist [TBL_DEPTH];
    logic [31:0] tbl_stamp [TBL_DEPTH];
    int          tbl_oldest = 0;
    int          tbl_next = 0;
    int          tbl_count = 0;

    ssc_pkg::rsp_t pending_rsp_q [$];
    dir_row_t      dir_rows [$];
    logic [31:0]   src_pool [POOL_SIZE];

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    bit hold_off_req = 1'b0;
    int fail_count = 0;
    int stall_cycles = 0;
    int n_sent = 0;
    int n_checked = 0;
    int n_kind [4] = '{0, 0, 0, 0};
    int n_full = 0;
    int n_empty = 0;
    int n_found = 0;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic ssc_pkg::rsp_t predict_cache(ssc_pkg::req_t r);
        ssc_pkg::rsp_t res;
        int   pos;
        int   hit;
        res = '0;
        hit = -1;
        pos = tbl_oldest;
        for (int k = 0; k < tbl_count; k++)
        begin
            if (hit < 0 && tbl_source[pos] == r.source &&
                (r.req_type == ssc_pkg::REQ_UPDATE || tbl_seq[pos] == r.sequence_req))
                hit = pos;
            pos = (pos + 1) % TBL_DEPTH;
        end
        case (r.req_type)
            ssc_pkg::REQ_UPDATE:
            begin
                if (hit < 0)
                begin
                    if (tbl_count >= TBL_DEPTH)
                    begin
                        res.status = ssc_pkg::STAT_FULL;
                        n_full++;
                    end
                    else
                    begin
                        tbl_source[tbl_next] = r.source;
                        tbl_seq[tbl_next] = r.sequence_req;
                        tbl_dist[tbl_next] = r.distance;
                        tbl_stamp[tbl_next] = r.now_ticks;
                        tbl_next = (tbl_next + 1) % TBL_DEPTH;
                        tbl_count++;
                        res.update_kind = ssc_pkg::KIND_SEQ;
                        res.entry_time = r.now_ticks;
                    end
                end
                else if (tbl_seq[hit] < r.sequence_req)
                begin
                    tbl_seq[hit] = r.sequence_req;
                    tbl_dist[hit] = r.distance;
                    tbl_stamp[hit] = r.now_ticks;
                    res.update_kind = ssc_pkg::KIND_SEQ;
                    res.entry_time = r.now_ticks;
                end
                else if (tbl_seq[hit] == r.sequence_req)
                begin
                    if (tbl_dist[hit] > r.distance)
                    begin
                        tbl_dist[hit] = r.distance;
                        res.update_kind = ssc_pkg::KIND_DIST;
                    end
                    else
                        res.update_kind = ssc_pkg::KIND_NONE;
                    res.entry_time = tbl_stamp[hit];
                end
                n_kind[res.update_kind]++;
            end
            ssc_pkg::REQ_LOOKUP:
            begin
                res.found = (hit >= 0);
                n_found += res.found;
            end
            ssc_pkg::REQ_REMOVE:
            begin
                if (tbl_count == 0)
                begin
                    res.status = ssc_pkg::STAT_EMPTY;
                    n_empty++;
                end
                else
                begin
                    tbl_oldest = (tbl_oldest + 1) % TBL_DEPTH;
                    tbl_count--;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic void add_row(logic [1:0] rt, logic [31:0] src, logic [31:0] seq,
                                    logic [15:0] hop, logic [31:0] now, bit typed,
                                    logic [1:0] kind, logic [31:0] stamp, logic fnd,
                                    logic [1:0] st);
        dir_row_t row;
        row.rq = '{req_type: rt, source: src, sequence_req: seq, distance: hop,
                   now_ticks: now};
        row.typed = typed;
        row.want = '{update_kind: kind, entry_time: stamp, found: fnd, status: st};
        dir_rows.push_back(row);
    endfunction

    function automatic ssc_pkg::req_t make_request(bit growing);
        ssc_pkg::req_t r;
        int   pick;
        int   k;
        pick = $urandom_range(0, 99);
        r.now_ticks = $urandom;
        r.source = src_pool[$urandom_range(0, POOL_SIZE - 1)];
        r.sequence_req = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 7);
        r.distance = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 15));
        if ($urandom_range(0, 19) == 0)
            r.source = $urandom;
        if (pick < 3)
            r.req_type = REQ_UNDEF;
        else if (pick < (growing ? 73 : 30))
            r.req_type = ssc_pkg::REQ_UPDATE;
        else if (pick < (growing ? 93 : 55))
        begin
            r.req_type = ssc_pkg::REQ_LOOKUP;
            // when the table is not empty, probe a stored pair half of the time
            if (tbl_count > 0 && $urandom_range(0, 1))
            begin
                k = (tbl_oldest + $urandom_range(0, tbl_count - 1)) % TBL_DEPTH;
                r.source = tbl_source[k];
                r.sequence_req = tbl_seq[k];
            end
        end
        else
            r.req_type = ssc_pkg::REQ_REMOVE;
        return r;
    endfunction

    task automatic send_item(input ssc_pkg::req_t item, input bit typed,
                             input ssc_pkg::rsp_t want);
        ssc_pkg::rsp_t predicted;
        int   gap;
        gap = 0;
        while ($urandom_range(0, 99) < tx_idle_pct)
            gap++;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req <= item;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (!req_ready);
        predicted = predict_cache(item);
        pending_rsp_q.push_back(typed ? want : predicted);
        n_sent++;
    endtask

    function automatic void check_rsp(ssc_pkg::rsp_t got);
        ssc_pkg::rsp_t want;
        if (pending_rsp_q.size() == 0)
        begin
            $error("unexpected transfer: kind %0d time %0h found %0d status %0d",
                   got.update_kind, got.entry_time, got.found, got.status);
            fail_count++;
            return;
        end
        want = pending_rsp_q.pop_front();
        n_checked++;
        if (got.update_kind !== want.update_kind)
        begin
            $error("update_kind: expected %0d, got %0d", want.update_kind, got.update_kind);
            fail_count++;
        end
        if (got.entry_time !== want.entry_time)
        begin
            $error("entry_time: expected %0h, got %0h", want.entry_time, got.entry_time);
            fail_count++;
        end
        if (got.found !== want.found)
        begin
            $error("found: expected %0d, got %0d", want.found, got.found);
            fail_count++;
        end
        if (got.status !== want.status)
        begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            fail_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
            check_rsp(rsp);
    end

    // receiver, with an optional long hold-off
    always
    begin
        @(posedge clk);
        if (hold_off_req)
        begin
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES - 1) @(posedge clk);
            hold_off_req = 1'b0;
        end
        else
            rsp_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
                stall_cycles <= 0;
            else if (stall_cycles >= STALL_LIMIT)
            begin
                $display("tb NOT OK");
                $finish;
            end
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    initial
    begin
        int            counted;
        int            seg_left;
        bit            growing;
        ssc_pkg::req_t item;
        ssc_pkg::rsp_t none;

        none = '0;
        for (int i = 0; i < POOL_SIZE; i++)
            src_pool[i] = $urandom;

        add_row(ssc_pkg::REQ_REMOVE, 32'h0, 32'h0, 16'h0, 32'h0,
                1, ssc_pkg::KIND_STALE, 32'h0, 0, ssc_pkg::STAT_EMPTY);
        add_row(ssc_pkg::REQ_LOOKUP, 32'h0, 32'h0, 16'h0, 32'h0,
                1, ssc_pkg::KIND_STALE, 32'h0, 0, ssc_pkg::STAT_OK);
        add_row(ssc_pkg::REQ_UPDATE, 32'h0, 32'h0, 16'hffff, 32'hffffffff,
                1, ssc_pkg::KIND_SEQ, 32'hffffffff, 0, ssc_pkg::STAT_OK);
        add_row(ssc_pkg::REQ_UPDATE, 32'hffffffff, 32'hffffffff, 16'h0, 32'h0,
                1, ssc_pkg::KIND_SEQ, 32'h0, 0, ssc_pkg::STAT_OK);
        add_row(ssc_pkg::REQ_UPDATE, 32'h0, 32'h0, 16'hffff, 32'h5,
                1, ssc_pkg::KIND_NONE, 32'hffffffff, 0, ssc_pkg::STAT_OK);
        add_row(ssc_pkg::REQ_UPDATE, 32'h0, 32'h0, 16'h1234, 32'h7,
                1, ssc_pkg::KIND_DIST, 32'hffffffff, 0, ssc_pkg::STAT_OK);
        add_row(ssc_pkg::REQ_UPDATE, 32'h0, 32'h5, 16'h9, 32'd100,
                1, ssc_pkg::KIND_SEQ, 32'd100, 0, ssc_pkg::STAT_OK);
        add_row(ssc_pkg::REQ_UPDATE, 32'h0, 32'h4, 16'h0, 32'd200,
                1, ssc_pkg::KIND_STALE, 32'h0, 0, ssc_pkg::STAT_OK);
        add_row(ssc_pkg::REQ_LOOKUP, 32'h0, 32'h5, 16'h0, 32'h0,
                1, ssc_pkg::KIND_STALE, 32'h0, 1, ssc_pkg::STAT_OK);
        add_row(ssc_pkg::REQ_LOOKUP, 32'h0, 32'h4, 16'h0, 32'h0,
                1, ssc_pkg::KIND_STALE, 32'h0, 0, ssc_pkg::STAT_OK);
        add_row(ssc_pkg::REQ_LOOKUP, 32'hffffffff, 32'hffffffff, 16'hffff, 32'hffffffff,
                1, ssc_pkg::KIND_STALE, 32'h0, 1, ssc_pkg::STAT_OK);
        add_row(REQ_UNDEF, 32'hffffffff, 32'hffffffff, 16'hffff, 32'hffffffff,
                1, ssc_pkg::KIND_STALE, 32'h0, 0, ssc_pkg::STAT_OK);
        add_row(ssc_pkg::REQ_UPDATE, 32'hffffffff, 32'hffffffff, 16'h0, 32'h3,
                0, ssc_pkg::KIND_STALE, 0, 0, ssc_pkg::STAT_OK);
        add_row(ssc_pkg::REQ_UPDATE, 32'h5a5a5a5a, 32'ha5a5a5a5, 16'h5a5a, 32'h12345678,
                0, ssc_pkg::KIND_STALE, 0, 0, ssc_pkg::STAT_OK);
        add_row(ssc_pkg::REQ_REMOVE, 32'h0, 32'h0, 16'h0, 32'h0,
                1, ssc_pkg::KIND_STALE, 32'h0, 0, ssc_pkg::STAT_OK);
        add_row(ssc_pkg::REQ_LOOKUP, 32'h0, 32'h5, 16'h0, 32'h0,
                1, ssc_pkg::KIND_STALE, 32'h0, 0, ssc_pkg::STAT_OK);
        add_row(ssc_pkg::REQ_UPDATE, 32'h0, 32'h1, 16'h1, 32'h42,
                0, ssc_pkg::KIND_STALE, 0, 0, ssc_pkg::STAT_OK);
        add_row(ssc_pkg::REQ_UPDATE, 32'h5a5a5a5a, 32'ha5a5a5a5, 16'h5a59, 32'h0,
                0, ssc_pkg::KIND_STALE, 0, 0, ssc_pkg::STAT_OK);
        add_row(ssc_pkg::REQ_REMOVE, 32'h0, 32'h0, 16'h0, 32'h0,
                0, ssc_pkg::KIND_STALE, 0, 0, ssc_pkg::STAT_OK);
        add_row(ssc_pkg::REQ_REMOVE, 32'h0, 32'h0, 16'h0, 32'h0,
                0, ssc_pkg::KIND_STALE, 0, 0, ssc_pkg::STAT_OK);
        add_row(ssc_pkg::REQ_REMOVE, 32'h0, 32'h0, 16'h0, 32'h0,
                0, ssc_pkg::KIND_STALE, 0, 0, ssc_pkg::STAT_OK);
        add_row(ssc_pkg::REQ_REMOVE, 32'h0, 32'h0, 16'h0, 32'h0,
                1, ssc_pkg::KIND_STALE, 32'h0, 0, ssc_pkg::STAT_EMPTY);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tx_idle_pct = 30;
        rx_idle_pct = 48;
        foreach (dir_rows[i])
            send_item(dir_rows[i].rq, dir_rows[i].typed, dir_rows[i].want);

        counted = 0;
        seg_left = 0;
        growing = 1'b0;
        while (counted < RANDOM_ITEMS)
        begin
            if (counted == RANDOM_ITEMS / 3)
            begin
                tx_idle_pct = 48;
                rx_idle_pct = 30;
            end
            else if (counted == 2 * RANDOM_ITEMS / 3)
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
                hold_off_req = 1'b1;
            end
            if (seg_left == 0)
            begin
                growing = !growing;
                seg_left = growing ? 200 : 60;
            end
            item = make_request(growing);
            send_item(item, 1'b0, none);
            seg_left--;
            if (item.req_type != REQ_UNDEF)
                counted++;
        end
        req_valid <= 1'b0;

        while (pending_rsp_q.size() != 0)
            @(posedge clk);
        repeat (TBL_DEPTH + 8) @(posedge clk);

        $display("%0d requests, %0d results checked; stale/none/dist/seq updates %0d/%0d/%0d/%0d",
                 n_sent, n_checked, n_kind[0], n_kind[1], n_kind[2], n_kind[3]);
        $display("lookup hits %0d, table-full refusals %0d, removes on empty %0d",
                 n_found, n_full, n_empty);
        if (fail_count == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
